FILE: hdl/rtgd_pkg.sv
// Package with shared constants and types for the RDS text group decoder.
`timescale 1ns / 1ps
`default_nettype none

package rtgd_pkg;

  // Text store geometry: radiotext is kept four characters to a memory row.
  localparam int unsigned RT_LEN     = 64;
  localparam int unsigned PS_LEN     = 8;
  localparam int unsigned RT_LANES   = 4;
  localparam int unsigned PS_LANES   = 2;
  localparam int unsigned RT_ROWS    = RT_LEN / RT_LANES;
  localparam int unsigned PS_ROWS    = PS_LEN / PS_LANES;
  localparam int unsigned RT_ROW_W   = $clog2(RT_ROWS);
  localparam int unsigned PS_ROW_W   = $clog2(PS_ROWS);
  localparam int unsigned RT_LANE_W  = $clog2(RT_LANES);
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned IDX_W      = $clog2(RT_LEN);

  // Item function codes.
  localparam logic FUNC_GROUP = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  // Group types handled.
  localparam logic [3:0] GT_BASIC     = 4'h0;
  localparam logic [3:0] GT_RADIOTEXT = 4'h2;

  // Error level limits.
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_RT_MAX = 2'd2;

  // Read-side information carried alongside the memory read.
  typedef struct packed {
    logic                         ps_ok;
    logic                         ps_fwd;
    logic [PS_LANES*CHAR_W-1:0]   ps_fwd_data;
    logic                         ps_lane;
    logic                         rt_ok;
    logic [RT_LANES-1:0]          rt_fwd_mask;
    logic [RT_LANES*CHAR_W-1:0]   rt_fwd_data;
    logic [RT_LANE_W-1:0]         rt_lane;
  } rd_info_t;

endpackage : rtgd_pkg

`default_nettype wire

FILE: hdl/rds_text_group_decoder.sv
// Top level of the RDS text group decoder: group decode, text memories and output stage.
// Results pass the stage-1 and output registers. Throughput: one item per cycle while
// the output is not stalled; the single write port and one read port of each text
// memory are used once per item, with same-row writes forwarded to the read.
// Reset clears the flags, the program type and the per-row valid bits of both text
// memories, so both stores read as zero at once; there is no clearing pass.
// A clear item drops the row valid bits.
`timescale 1ns / 1ps
`default_nettype none

module rds_text_group_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        func_i,
  input  wire logic [15:0] status_word_i,
  input  wire logic [15:0] block_b_i,
  input  wire logic [15:0] block_c_i,
  input  wire logic [15:0] block_d_i,
  input  wire logic [15:0] error_word_i,
  input  wire logic [5:0]  read_index_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             music_speech_o,
  output logic             traffic_announce_o,
  output logic [4:0]       program_type_o,
  output logic [7:0]       ps_char_o,
  output logic [7:0]       rt_char_o,
  output logic             text_updated_o
);

  localparam int unsigned CW  = rtgd_pkg::CHAR_W;
  localparam int unsigned RTW = rtgd_pkg::RT_LANES * CW;
  localparam int unsigned PSW = rtgd_pkg::PS_LANES * CW;

  // Text memories.
  logic [RTW-1:0] rt_mem [rtgd_pkg::RT_ROWS];
  logic [PSW-1:0] ps_mem [rtgd_pkg::PS_ROWS];
  logic [RTW-1:0] rt_rdata_q;
  logic [PSW-1:0] ps_rdata_q;

  logic [rtgd_pkg::RT_ROWS-1:0] rt_vld_q, rt_vld_d;
  logic [rtgd_pkg::PS_ROWS-1:0] ps_vld_q, ps_vld_d;

  logic       ms_q, ms_d, ta_q, ta_d;
  logic [4:0] pty_q, pty_d;

  logic                 s1_valid_q;
  logic                 s1_ms_q, s1_ta_q, s1_upd_q;
  logic [4:0]           s1_pty_q;
  rtgd_pkg::rd_info_t   s1_info_q, info_d;

  logic in_fire, s1_adv;

  // Decode of the incoming group.
  logic                          grp_ok, basic, rt_a, rt_b, ps_we, rt_we, updated;
  logic [3:0]                    gtype, seg;
  logic [1:0]                    err_b, err_c, err_d;
  logic [rtgd_pkg::RT_LANES-1:0] rt_be, rt_wbe;
  logic [RTW-1:0]                rt_src, rt_wdata;
  logic [rtgd_pkg::RT_ROW_W-1:0] rt_row, rt_rd_row;
  logic [rtgd_pkg::PS_ROW_W-1:0] ps_row, ps_rd_row;

  assign s1_adv     = s1_valid_q && (!out_valid_o || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  assign rt_rd_row = read_index_i[rtgd_pkg::IDX_W-1 -: rtgd_pkg::RT_ROW_W];
  assign ps_rd_row = read_index_i[rtgd_pkg::PS_ROW_W:1];

  always_comb begin
    grp_ok = (func_i == rtgd_pkg::FUNC_GROUP) && status_word_i[15];
    gtype  = block_b_i[15:12];
    seg    = block_b_i[3:0];
    err_b  = error_word_i[13:12];
    err_c  = error_word_i[11:10];
    err_d  = error_word_i[9:8];
    basic  = grp_ok && (gtype == rtgd_pkg::GT_BASIC);
    rt_a   = grp_ok && (gtype == rtgd_pkg::GT_RADIOTEXT) && !status_word_i[12];
    rt_b   = grp_ok && (gtype == rtgd_pkg::GT_RADIOTEXT) && status_word_i[12];
    ps_we  = basic && (err_b == rtgd_pkg::ERR_NONE) && (err_d == rtgd_pkg::ERR_NONE);
    ps_row = block_b_i[rtgd_pkg::PS_ROW_W-1:0];

    // Lane 0 holds the lowest character position of a row.
    rt_be  = '0;
    rt_src = {block_d_i[7:0], block_d_i[15:8], block_d_i[7:0], block_d_i[15:8]};
    rt_row = seg;
    if (rt_a) begin
      rt_src = {block_d_i[7:0], block_d_i[15:8], block_c_i[7:0], block_c_i[15:8]};
      rt_be  = {{2{err_d < rtgd_pkg::ERR_RT_MAX}}, {2{err_c < rtgd_pkg::ERR_RT_MAX}}};
    end else if (rt_b) begin
      rt_row = {1'b0, seg[3:1]};
      if (err_d == rtgd_pkg::ERR_NONE) begin
        rt_be = seg[0] ? 4'b1100 : 4'b0011;
      end
    end
    rt_we   = |rt_be;
    updated = ps_we || rt_we;

    // A row that is not valid reads as zero, so its first write fills all lanes.
    rt_wbe = rt_vld_q[rt_row] ? rt_be : '1;
    for (int l = 0; l < rtgd_pkg::RT_LANES; l++) begin
      rt_wdata[l*CW +: CW] = rt_be[l] ? rt_src[l*CW +: CW] : '0;
    end

    rt_vld_d = rt_vld_q;
    ps_vld_d = ps_vld_q;
    if (func_i == rtgd_pkg::FUNC_CLEAR) begin
      rt_vld_d = '0;
      ps_vld_d = '0;
    end else begin
      if (rt_we) rt_vld_d[rt_row] = 1'b1;
      if (ps_we) ps_vld_d[ps_row] = 1'b1;
    end

    ms_d  = basic ? block_b_i[3] : ms_q;
    ta_d  = basic ? block_b_i[4] : ta_q;
    pty_d = basic ? block_b_i[9:5] : pty_q;

    info_d.ps_ok       = ps_vld_d[ps_rd_row];
    info_d.ps_fwd      = ps_we && (ps_row == ps_rd_row);
    info_d.ps_fwd_data = block_d_i;
    info_d.ps_lane     = read_index_i[0];
    info_d.rt_ok       = rt_vld_d[rt_rd_row];
    info_d.rt_fwd_mask = (rt_we && (rt_row == rt_rd_row)) ? rt_wbe : '0;
    info_d.rt_fwd_data = rt_wdata;
    info_d.rt_lane     = read_index_i[rtgd_pkg::RT_LANE_W-1:0];
  end

  // Memories: one write and one registered read per accepted item.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      for (int l = 0; l < rtgd_pkg::RT_LANES; l++) begin
        if (rt_we && rt_wbe[l]) begin
          rt_mem[rt_row][l*CW +: CW] <= rt_wdata[l*CW +: CW];
        end
      end
      if (ps_we) begin
        ps_mem[ps_row] <= block_d_i;
      end
      rt_rdata_q <= rt_mem[rt_rd_row];
      ps_rdata_q <= ps_mem[ps_rd_row];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rt_vld_q   <= '0;
      ps_vld_q   <= '0;
      ms_q       <= 1'b0;
      ta_q       <= 1'b0;
      pty_q      <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        rt_vld_q <= rt_vld_d;
        ps_vld_q <= ps_vld_d;
        ms_q     <= ms_d;
        ta_q     <= ta_d;
        pty_q    <= pty_d;
      end
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_ms_q   <= ms_d;
      s1_ta_q   <= ta_d;
      s1_pty_q  <= pty_d;
      s1_upd_q  <= updated;
      s1_info_q <= info_d;
    end
  end

  // Merge of read data with a write to the same row from the same item.
  logic [PSW-1:0] ps_row_data;
  logic [RTW-1:0] rt_row_data;
  logic [CW-1:0]  ps_char_d, rt_char_d;

  always_comb begin
    ps_row_data = s1_info_q.ps_fwd ? s1_info_q.ps_fwd_data : ps_rdata_q;
    for (int l = 0; l < rtgd_pkg::RT_LANES; l++) begin
      rt_row_data[l*CW +: CW] = s1_info_q.rt_fwd_mask[l] ?
                                s1_info_q.rt_fwd_data[l*CW +: CW] : rt_rdata_q[l*CW +: CW];
    end
    // Even PS positions sit in the high byte of a row.
    ps_char_d = s1_info_q.ps_lane ? ps_row_data[CW-1:0] : ps_row_data[PSW-1 -: CW];
    rt_char_d = rt_row_data[s1_info_q.rt_lane*CW +: CW];
    if (!s1_info_q.ps_ok) ps_char_d = '0;
    if (!s1_info_q.rt_ok) rt_char_d = '0;
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (!out_valid_o || out_ready_i) begin
      out_valid_o <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      music_speech_o     <= s1_ms_q;
      traffic_announce_o <= s1_ta_q;
      program_type_o     <= s1_pty_q;
      ps_char_o          <= ps_char_d;
      rt_char_o          <= rt_char_d;
      text_updated_o     <= s1_upd_q;
    end
  end

endmodule : rds_text_group_decoder

`default_nettype wire
